### hw/rtl/rte_pkg.sv
// shared constants, types and codes of the route table engine
`default_nettype none
package rte_pkg;
    localparam int NODES           = 32;
    localparam int ROUTES_PER_DEST = 8;
    localparam int DUMP_NODES      = (NODES < 32) ? NODES : 32;
    localparam int NIDX_W          = $clog2(NODES);
    localparam int CNT_W           = $clog2(ROUTES_PER_DEST + 1);
    localparam int ADDR_W          = $clog2(NODES * ROUTES_PER_DEST);
    localparam int DEPTH           = NODES * ROUTES_PER_DEST;

    localparam logic [7:0] UNREACHABLE_COST = 8'd255;
    localparam logic [7:0] NEIGHBOUR_COST   = 8'd1;

    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_EXISTS  = 3'd1,
        KIND_DELETE  = 3'd2,
        KIND_UNREACH = 3'd3,
        KIND_LOOKUP  = 3'd4,
        KIND_DUMP    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RD,
        ST_EV,
        ST_FIN,
        ST_DRD,
        ST_DEV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] hop;
        logic [7:0] cost;
    } slot_t;

    // result beat, lowest field last in the packed order
    typedef struct packed {
        logic       status;
        logic       is_neighbour;
        logic       found;
        logic [7:0] via_hop;
        logic [7:0] route_cost;
        logic [4:0] node;
    } result_t;
endpackage
`default_nettype wire

### hw/rtl/rte_slot_ram.sv
// route slot memory, one write and one registered read port
`default_nettype none
module rte_slot_ram (
    input  wire                        aclk,
    input  wire                        we,
    input  wire  [rte_pkg::ADDR_W-1:0] waddr,
    input  wire  rte_pkg::slot_t       wdata,
    input  wire                        re,
    input  wire  [rte_pkg::ADDR_W-1:0] raddr,
    output rte_pkg::slot_t             rdata
);
    import rte_pkg::*;

    slot_t mem [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### hw/rtl/route_table_engine.sv
// route table engine top level: sequencer, route counts and result register
// sequence: add/exists/delete/lookup read and evaluate the stored slots of the destination in turn,
//   delete then shifts each later slot down; hop-unreachable scans the stored routes of every node;
//   dump scans the stored routes of each node and gives one beat per node
// one item at a time; each slot is read, then evaluated
// reset: route counts cleared, infinity cost back to 255, no beat pending; slots not cleared
`default_nettype none
module route_table_engine (
    input  wire         aclk,
    input  wire         aresetn,
    // input beats
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // dest[4:0], hop[12:5], cost[20:13], poison_enable[21], zero
    input  wire  [2:0]  s_tuser,   // kind[2:0]
    // result beats
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // node[4:0], route_cost[12:5], via_hop[20:13], found[21],
                                   // is_neighbour[22], status[23]
    output logic        m_tlast,
    // infinity-cost register write
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data
);
    import rte_pkg::*;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [4:0]        dest_reg, dest_next;
    logic [7:0]        hop_reg, hop_next;
    logic [7:0]        cost_reg, cost_next;
    logic              poison_reg, poison_next;
    logic [NIDX_W-1:0] node_reg, node_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic              status_reg, status_next;
    logic              best_ok_reg, best_ok_next;
    logic [7:0]        best_cost_reg, best_cost_next;
    logic [7:0]        best_hop_reg, best_hop_next;
    logic [7:0]        inf_cost_reg;

    // per-destination route counts, cleared at reset
    logic [CNT_W-1:0]  cnt_reg [NODES];
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wval;

    // result register
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    // slot memory port signals
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    slot_t             mem_wdata, mem_rdata;

    logic [CNT_W-1:0]  cnt_cur;
    logic [CNT_W-1:0]  idx_inc;
    logic [ADDR_W-1:0] base_addr;
    logic              dest_ok;
    logic              in_beat;
    logic              out_free;
    logic              hop_hit;
    logic              is_find;
    logic              last_node;
    logic              dump_last;
    kind_t             in_kind;
    logic              in_kind_ok;

    rte_slot_ram u_slot_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign in_kind   = kind_t'(s_tuser);
    assign in_kind_ok = (s_tuser <= 3'(KIND_DUMP));

    assign cnt_cur   = cnt_reg[node_reg];
    assign idx_inc   = idx_reg + 1'b1;
    assign base_addr = ADDR_W'(node_reg) * ADDR_W'(ROUTES_PER_DEST);
    assign dest_ok   = (32'(dest_reg) < NODES);
    assign hop_hit   = (mem_rdata.hop == hop_reg);
    assign is_find   = (kind_reg == KIND_ADD) || (kind_reg == KIND_EXISTS)
                    || (kind_reg == KIND_DELETE);
    assign last_node = (node_reg == NIDX_W'(NODES - 1));
    assign dump_last = (node_reg == NIDX_W'(DUMP_NODES - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && in_kind_ok) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if ((kind_reg != KIND_UNREACH) && (kind_reg != KIND_DUMP) && !dest_ok) begin
                    state_next = ST_EMIT;
                end else if (cnt_cur == '0) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                if ((is_find && hop_hit) || (idx_inc >= cnt_cur)) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_FIN: begin
                if (kind_reg == KIND_DELETE && found_reg && idx_inc < cnt_cur) begin
                    state_next = ST_DRD;
                end else if (kind_reg == KIND_UNREACH && !last_node) begin
                    state_next = ST_START;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DRD: begin
                state_next = ST_DEV;
            end
            ST_DEV: begin
                if (CNT_W'(idx_inc + 1'b1) >= cnt_cur) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DRD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (kind_reg == KIND_DUMP && !dump_last) begin
                        state_next = ST_START;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        kind_next      = kind_reg;
        dest_next      = dest_reg;
        hop_next       = hop_reg;
        cost_next      = cost_reg;
        poison_next    = poison_reg;
        node_next      = node_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        best_ok_next   = best_ok_reg;
        best_cost_next = best_cost_reg;
        best_hop_next  = best_hop_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        cnt_we         = 1'b0;
        cnt_wval       = cnt_cur;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = base_addr + ADDR_W'(idx_reg);
        mem_raddr      = base_addr + ADDR_W'(idx_reg);
        mem_wdata      = '{hop: hop_reg, cost: cost_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    kind_next      = in_kind;
                    dest_next      = s_tdata[4:0];
                    hop_next       = s_tdata[12:5];
                    cost_next      = s_tdata[20:13];
                    poison_next    = s_tdata[21];
                    idx_next       = '0;
                    found_next     = 1'b0;
                    status_next    = 1'b0;
                    best_ok_next   = 1'b0;
                    best_cost_next = inf_cost_reg;
                    best_hop_next  = '0;
                    if (in_kind == KIND_UNREACH || in_kind == KIND_DUMP) begin
                        node_next = '0;
                    end else begin
                        node_next = NIDX_W'(s_tdata[4:0]);
                    end
                end
            end
            ST_START: begin
                idx_next = '0;
                // out-of-range destination: an add is refused
                if (!dest_ok && kind_reg == KIND_ADD) begin
                    status_next = 1'b1;
                end
            end
            ST_RD: begin
                mem_re = 1'b1;
            end
            ST_EV: begin
                priority if (kind_reg == KIND_LOOKUP || kind_reg == KIND_DUMP) begin
                    if (mem_rdata.cost < best_cost_reg) begin
                        best_ok_next   = 1'b1;
                        best_cost_next = mem_rdata.cost;
                        best_hop_next  = mem_rdata.hop;
                    end
                end else if (kind_reg == KIND_UNREACH) begin
                    if (hop_hit) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{hop: mem_rdata.hop, cost: UNREACHABLE_COST};
                    end
                end else begin
                    if (hop_hit) begin
                        found_next = 1'b1;
                    end
                end
                // keep idx on the matching slot
                if (!(is_find && hop_hit) && idx_inc < cnt_cur) begin
                    idx_next = idx_inc;
                end
            end
            ST_FIN: begin
                if (kind_reg == KIND_ADD) begin
                    priority if (found_reg) begin
                        mem_we = 1'b1;
                    end else if (32'(cnt_cur) < ROUTES_PER_DEST) begin
                        mem_we    = 1'b1;
                        mem_waddr = base_addr + ADDR_W'(cnt_cur);
                        cnt_we    = 1'b1;
                        cnt_wval  = cnt_cur + 1'b1;
                    end else begin
                        status_next = 1'b1;
                    end
                end
                if (kind_reg == KIND_UNREACH && !last_node) begin
                    node_next = node_reg + 1'b1;
                end
            end
            ST_DRD: begin
                mem_re    = 1'b1;
                mem_raddr = base_addr + ADDR_W'(idx_inc);
            end
            ST_DEV: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                idx_next  = idx_inc;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_data_next  = '0;
                    m_data_next.node = dest_reg;
                    unique case (kind_reg)
                        KIND_ADD: m_data_next.status = status_reg;
                        KIND_EXISTS: m_data_next.found = found_reg;
                        KIND_DELETE: begin
                            if (found_reg) begin
                                cnt_we   = 1'b1;
                                cnt_wval = cnt_cur - 1'b1;
                            end
                        end
                        KIND_UNREACH: m_data_next.node = '0;
                        KIND_LOOKUP: begin
                            m_data_next.route_cost = best_cost_reg;
                            m_data_next.via_hop    = best_hop_reg;
                            m_data_next.found      = best_ok_reg;
                        end
                        KIND_DUMP: begin
                            m_data_next.node         = 5'(node_reg);
                            m_data_next.route_cost   = (poison_reg && best_hop_reg == hop_reg)
                                                     ? inf_cost_reg : best_cost_reg;
                            m_data_next.via_hop      = best_hop_reg;
                            m_data_next.found        = best_ok_reg;
                            m_data_next.is_neighbour = (best_cost_reg == NEIGHBOUR_COST);
                            m_last_next              = dump_last;
                            if (!dump_last) begin
                                node_next      = node_reg + 1'b1;
                                best_ok_next   = 1'b0;
                                best_cost_next = inf_cost_reg;
                                best_hop_next  = '0;
                            end
                        end
                        default: m_data_next = '0;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            inf_cost_reg <= UNREACHABLE_COST;
            for (int n = 0; n < NODES; n++) begin
                cnt_reg[n] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                inf_cost_reg <= cfg_data;
            end
            if (cnt_we) begin
                cnt_reg[node_reg] <= cnt_wval;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        dest_reg      <= dest_next;
        hop_reg       <= hop_next;
        cost_reg      <= cost_next;
        poison_reg    <= poison_next;
        node_reg      <= node_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        best_ok_reg   <= best_ok_next;
        best_cost_reg <= best_cost_next;
        best_hop_reg  <= best_hop_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
endmodule
`default_nettype wire

### hw/rtl/rte_checker.sv
// port-level checker for the route table engine and its bind
`default_nettype none
module rte_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [2:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire        m_tlast,
    input wire        cfg_ready
);
    import rte_pkg::*;

    // a pending result beat stays until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // a valid operation beat closes the input until its run is done
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser <= 3'(KIND_DUMP) |=> !s_tready)
        else $error("input taken while an operation runs");

    // reset leaves no result beat pending and the register port open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && cfg_ready)
        else $error("bad state after reset");
endmodule

bind route_table_engine rte_checker u_rte_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

### tb/tb_top.sv
// testbench of the route table engine: route table predictor, random traffic, beat checks
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rte_pkg::*;

    // one expected result beat
    typedef struct {
        logic [4:0] node;
        logic [7:0] route_cost;
        logic [7:0] via_hop;
        logic       found;
        logic       is_neighbour;
        logic       status;
        logic       last;
    } rte_beat_t;

    // route table predictor with its own copy of the table and of the infinity cost
    class route_scoreboard;
        logic [7:0] hop_mem [DEPTH];
        logic [7:0] cost_mem [DEPTH];
        int unsigned cnt [NODES];
        logic [7:0] inf_cost;
        rte_beat_t pending [$];
        int errors;

        function void init();
            for (int n = 0; n < NODES; n++) cnt[n] = 0;
            inf_cost = 8'd255;
            errors = 0;
        endfunction

        function int slot_of(int d, logic [7:0] h);
            for (int i = 0; i < cnt[d]; i++)
                if (hop_mem[d * ROUTES_PER_DEST + i] == h) return i;
            return -1;
        endfunction

        // cheapest counting route of d; earliest wins on a tie
        function void best_route(int d, output logic ok, output logic [7:0] bh,
                                 output logic [7:0] bc);
            ok = 0; bh = 0; bc = inf_cost;
            if (d >= NODES) return;
            for (int i = 0; i < cnt[d]; i++)
                if (cost_mem[d * ROUTES_PER_DEST + i] < bc) begin
                    ok = 1;
                    bc = cost_mem[d * ROUTES_PER_DEST + i];
                    bh = hop_mem[d * ROUTES_PER_DEST + i];
                end
        endfunction

        function void push(logic [4:0] nd, logic [7:0] rc, logic [7:0] nh,
                           logic f, logic nb, logic st, logic lst);
            rte_beat_t b;
            b.node = nd; b.route_cost = rc; b.via_hop = nh; b.found = f;
            b.is_neighbour = nb; b.status = st; b.last = lst;
            pending.push_back(b);
        endfunction

        // note an accepted input beat and queue what it should produce
        function void note_input(logic [2:0] k, logic [4:0] d, logic [7:0] h,
                                 logic [7:0] c, logic p);
            int s;
            int base;
            logic ok;
            logic [7:0] bh, bc, rc;
            base = d * ROUTES_PER_DEST;
            case (k)
                KIND_ADD: begin
                    s = slot_of(d, h);
                    if (s >= 0) begin
                        cost_mem[base + s] = c;
                        push(d, 0, 0, 0, 0, 0, 1);
                    end else if (cnt[d] < ROUTES_PER_DEST) begin
                        hop_mem[base + cnt[d]] = h;
                        cost_mem[base + cnt[d]] = c;
                        cnt[d]++;
                        push(d, 0, 0, 0, 0, 0, 1);
                    end else begin
                        push(d, 0, 0, 0, 0, 1, 1);
                    end
                end
                KIND_EXISTS: push(d, 0, 0, slot_of(d, h) >= 0, 0, 0, 1);
                KIND_DELETE: begin
                    s = slot_of(d, h);
                    if (s >= 0) begin
                        for (int i = s; i + 1 < cnt[d]; i++) begin
                            hop_mem[base + i] = hop_mem[base + i + 1];
                            cost_mem[base + i] = cost_mem[base + i + 1];
                        end
                        cnt[d]--;
                    end
                    push(d, 0, 0, 0, 0, 0, 1);
                end
                KIND_UNREACH: begin
                    for (int n = 0; n < NODES; n++)
                        for (int i = 0; i < cnt[n]; i++)
                            if (hop_mem[n * ROUTES_PER_DEST + i] == h)
                                cost_mem[n * ROUTES_PER_DEST + i] = UNREACHABLE_COST;
                    push(0, 0, 0, 0, 0, 0, 1);
                end
                KIND_LOOKUP: begin
                    best_route(d, ok, bh, bc);
                    push(d, bc, bh, ok, 0, 0, 1);
                end
                KIND_DUMP: begin
                    for (int n = 0; n < DUMP_NODES; n++) begin
                        best_route(n, ok, bh, bc);
                        rc = (p && bh == h) ? inf_cost : bc;
                        push(5'(n), rc, bh, ok, bc == NEIGHBOUR_COST, 0,
                             n == DUMP_NODES - 1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [23:0] data, logic lst);
            rte_beat_t e;
            if (pending.size() == 0) begin
                report("unexpected beat", 32'(data), 0);
                return;
            end
            e = pending.pop_front();
            if (data[4:0] != e.node) report("node", 32'(data[4:0]), 32'(e.node));
            if (data[12:5] != e.route_cost)
                report("route_cost", 32'(data[12:5]), 32'(e.route_cost));
            if (data[20:13] != e.via_hop)
                report("via_hop", 32'(data[20:13]), 32'(e.via_hop));
            if (data[21] != e.found) report("found", 32'(data[21]), 32'(e.found));
            if (data[22] != e.is_neighbour)
                report("is_neighbour", 32'(data[22]), 32'(e.is_neighbour));
            if (data[23] != e.status) report("status", 32'(data[23]), 32'(e.status));
            if (lst != e.last) report("last", 32'(lst), 32'(e.last));
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = 0;
    logic [2:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 0;

    route_scoreboard route_sb;
    int  idle_cycles = 0;
    bit  hold_off = 0;     // long receiver hold-off request
    bit  stall_on = 1;     // random receiver stalls enabled
    localparam int WATCHDOG_LIMIT = 20000;

    route_table_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // sample both channels at the edge; outputs seen before the nonblocking updates land
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) route_sb.check_result(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on a stalled run
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: own stall pattern, with the long hold-off when asked
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 0;
        else if (!stall_on) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // one input beat; waits for acceptance
    task automatic send_item(logic [2:0] k, logic [4:0] d, logic [7:0] h,
                             logic [7:0] c, logic p);
        s_tvalid <= 1;
        s_tuser <= k;
        s_tdata <= {2'b0, p, c, h, d};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        route_sb.note_input(k, d, h, c, p);
    endtask

    task automatic gap(int n);
        s_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    // wait for all beats, then let the block settle before a register write
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (route_sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_inf_cost(logic [7:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        route_sb.inf_cost = v;
        @(posedge aclk);
    endtask

    // random item: mostly table traffic on a few destinations and hops
    task automatic random_item();
        logic [2:0] k;
        logic [4:0] d;
        logic [7:0] h, c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) k = KIND_ADD;
        else if (r < 55) k = KIND_EXISTS;
        else if (r < 70) k = KIND_DELETE;
        else if (r < 77) k = KIND_UNREACH;
        else if (r < 94) k = KIND_LOOKUP;
        else if (r < 97) k = KIND_DUMP;
        else k = 3'(3'd6 + $urandom_range(0, 1));
        d = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3));
        h = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 11));
        c = 8'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
        send_item(k, d, h, c, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                random_item();
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 20));
        end
    endtask

    initial begin
        route_sb = new();
        route_sb.init();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, every kind, full list, update, missing, ties, poison
        send_item(KIND_LOOKUP, 0, 0, 0, 0);
        send_item(KIND_ADD, 0, 8'd255, 8'd0, 0);
        send_item(KIND_ADD, 0, 8'd1, 8'd0, 0);
        send_item(KIND_ADD, 0, 8'd1, 8'd1, 0);
        for (int i = 2; i < 9; i++) send_item(KIND_ADD, 0, 8'(i), 8'd255, 0);
        send_item(KIND_EXISTS, 0, 8'd255, 0, 0);
        send_item(KIND_EXISTS, 0, 8'd77, 0, 0);
        send_item(KIND_DELETE, 0, 8'd77, 0, 0);
        send_item(KIND_DELETE, 0, 8'd255, 0, 0);
        send_item(KIND_LOOKUP, 0, 0, 0, 0);
        send_item(KIND_ADD, 31, 8'd9, 8'd1, 0);
        send_item(KIND_ADD, 31, 8'd10, 8'd1, 0);
        send_item(KIND_LOOKUP, 31, 0, 0, 0);
        send_item(KIND_DUMP, 0, 8'd1, 0, 1);
        send_item(KIND_UNREACH, 0, 8'd1, 0, 0);
        send_item(3'd7, 31, 8'd255, 8'd255, 1);
        send_item(KIND_DUMP, 31, 8'd9, 8'd255, 0);
        drain();

        write_inf_cost(8'd1);
        random_phase(60);
        drain();
        write_inf_cost(8'd255);

        // pressure: receiver holds off for a long stretch while items keep coming
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            random_phase(30);
        join
        stall_on = 0;
        random_phase(80);
        stall_on = 1;
        drain();

        write_inf_cost(8'd4);
        random_phase(150);
        drain();
        write_inf_cost(8'd128);
        random_phase(140);
        drain();

        if (route_sb.errors == 0 && route_sb.pending.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
